// ===== hw/rtl/rxdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rxdr_pkg
// Shared constants, codes and types of the receive descriptor ring frame
// assembler.
// ----------------------------------------------------------------------------
package rxdr_pkg;

    // Ring geometry
    localparam int RING_ENTRIES  = 32;
    localparam int SEGMENT_BYTES = 128;

    localparam int PTR_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int CNT_W = $clog2(RING_ENTRIES + 1);

    // Field widths
    localparam int IDX_W = 5;
    localparam int LEN_W = 12;
    localparam int SEG_W = 8;
    localparam int ACT_W = 2;
    localparam int STS_W = 2;

    // Item function codes
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_RECEIVE = 1'b1;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_FRAG  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COPY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DROP  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FINAL = 2'd3;

    // Final status codes
    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_FRAME = 2'd1;
    localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_STEP,
        ST_FINAL
    } walk_state_t;

    typedef enum logic {
        PH_HUNT,
        PH_ASM
    } phase_t;

    // Descriptor fields held in the ring memory
    typedef struct packed {
        logic             frame_start;
        logic             frame_end;
        logic [LEN_W-1:0] frame_length;
    } desc_t;

    // Ring memory write request
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        desc_t            data;
    } ram_wr_t;

    // Verdict on one segment of a frame
    typedef struct packed {
        logic             copy;
        logic             ovf;
        logic [SEG_W-1:0] seg_bytes;
        logic [LEN_W-1:0] new_size;
    } seg_eval_t;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0] released_entry;
        logic [ACT_W-1:0] action;
        logic [LEN_W-1:0] dest_offset;
        logic [SEG_W-1:0] segment_bytes;
        logic [STS_W-1:0] status;
        logic [LEN_W-1:0] frame_size;
        logic             last;
    } result_t;

endpackage

// ===== hw/rtl/rxdr_desc_ram.sv =====
// ----------------------------------------------------------------------------
// rxdr_desc_ram
// Descriptor memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rxdr_desc_ram (
    input  logic                           clk,
    input  rxdr_pkg::ram_wr_t              wr,
    input  logic [rxdr_pkg::PTR_W-1:0]     rd_addr,
    output rxdr_pkg::desc_t                rd_data
);

    rxdr_pkg::desc_t desc_mem [rxdr_pkg::RING_ENTRIES];
    rxdr_pkg::desc_t rd_data_reg;

    // Write one descriptor
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            desc_mem[wr.addr] <= wr.data;
        end
    end

    // Read one descriptor into the registered read data
    always_ff @(posedge clk)
    begin
        rd_data_reg <= desc_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rxdr_seg_eval.sv =====
// ----------------------------------------------------------------------------
// rxdr_seg_eval
// Judges one segment of a frame against the caller capacity and the segment
// size, and gives the bytes to copy and the new assembled size.
// ----------------------------------------------------------------------------
module rxdr_seg_eval (
    input  logic [rxdr_pkg::LEN_W-1:0] size,
    input  logic                       ovf_in,
    input  logic                       is_end,
    input  logic [rxdr_pkg::LEN_W-1:0] length,
    input  logic [rxdr_pkg::LEN_W-1:0] cap,
    output rxdr_pkg::seg_eval_t        res
);

    localparam logic [rxdr_pkg::LEN_W:0] SEG_MAX = (rxdr_pkg::LEN_W + 1)'(rxdr_pkg::SEGMENT_BYTES);

    logic [rxdr_pkg::LEN_W:0]   mid_total;
    logic [rxdr_pkg::LEN_W-1:0] seg_len;
    logic                       ovf;

    assign mid_total = {1'b0, size} + SEG_MAX;

    // Size the segment and flag overflow
    always_comb
    begin
        seg_len = '0;
        ovf     = ovf_in;
        if (is_end)
        begin
            if (length < size)
            begin
                ovf = 1'b1;
            end
            else
            begin
                seg_len = length - size;
                if ((length > cap) || ({1'b0, seg_len} > SEG_MAX))
                begin
                    ovf = 1'b1;
                end
            end
        end
        else
        begin
            seg_len = SEG_MAX[rxdr_pkg::LEN_W-1:0];
            if (mid_total > {1'b0, cap})
            begin
                ovf = 1'b1;
            end
        end
    end

    // Copy only while no overflow stands
    always_comb
    begin
        res.ovf  = ovf;
        res.copy = !ovf;
        if (!ovf)
        begin
            res.seg_bytes = seg_len[rxdr_pkg::SEG_W-1:0];
            res.new_size  = size + seg_len;
        end
        else
        begin
            res.seg_bytes = '0;
            res.new_size  = size;
        end
    end

endmodule

// ===== hw/rtl/rxdr_walker.sv =====
// ----------------------------------------------------------------------------
// rxdr_walker
// Ring walk sequencer: holds the owned bits and the read pointer, writes
// descriptors, steps one entry a cycle through the descriptor memory while
// the output is not stalled, and produces the result items of a receive.
// ----------------------------------------------------------------------------
module rxdr_walker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [rxdr_pkg::IDX_W-1:0]     entry_index,
    input  logic                           is_frame_start,
    input  logic                           is_frame_end,
    input  logic [rxdr_pkg::LEN_W-1:0]     frame_length,
    input  logic [rxdr_pkg::LEN_W-1:0]     capacity,
    input  logic                           res_ready,
    output logic                           res_valid,
    output rxdr_pkg::result_t              res,
    output rxdr_pkg::ram_wr_t              ram_wr,
    output logic [rxdr_pkg::PTR_W-1:0]     ram_rd_addr,
    input  rxdr_pkg::desc_t                ram_rd_data
);

    rxdr_pkg::walk_state_t              state_reg, state_next;
    rxdr_pkg::phase_t                   phase_reg, phase_next;
    logic [rxdr_pkg::PTR_W-1:0]         rp_reg, rp_next;
    logic [rxdr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [rxdr_pkg::LEN_W-1:0]         size_reg, size_next;
    logic                               ovf_reg, ovf_next;
    logic                               found_reg, found_next;
    logic [rxdr_pkg::LEN_W-1:0]         cap_reg, cap_next;
    logic [rxdr_pkg::RING_ENTRIES-1:0]  owned_reg, owned_next;

    logic                               in_accept;
    logic                               idx_ok;
    logic [rxdr_pkg::PTR_W-1:0]         wr_idx;
    logic [rxdr_pkg::PTR_W-1:0]         rp_adv;
    logic                               cur_owned;
    logic                               step_go;
    logic                               restart;
    logic                               is_frag;
    logic                               is_seg;
    logic                               last_step;
    logic [rxdr_pkg::LEN_W-1:0]         base_size;
    logic                               base_ovf;
    rxdr_pkg::seg_eval_t                seg;

    assign in_accept = in_valid && (state_reg == rxdr_pkg::ST_IDLE);
    assign idx_ok    = {1'b0, entry_index} < (rxdr_pkg::IDX_W + 1)'(rxdr_pkg::RING_ENTRIES);
    assign wr_idx    = entry_index[rxdr_pkg::PTR_W-1:0];
    assign rp_adv    = (rp_reg == rxdr_pkg::PTR_W'(rxdr_pkg::RING_ENTRIES - 1)) ?
                       '0 : rp_reg + 1'b1;
    assign cur_owned = owned_reg[rp_reg];
    assign step_go   = (state_reg == rxdr_pkg::ST_STEP) && res_ready;

    // Classify the entry under the pointer
    assign is_frag   = cur_owned && (phase_reg == rxdr_pkg::PH_HUNT) &&
                       !ram_rd_data.frame_start;
    assign is_seg    = cur_owned && !is_frag;
    assign restart   = (phase_reg == rxdr_pkg::PH_HUNT) ||
                       (ram_rd_data.frame_start && (size_reg != '0));
    assign base_size = restart ? '0 : size_reg;
    assign base_ovf  = restart ? 1'b0 : ovf_reg;
    assign last_step = (cnt_reg == rxdr_pkg::CNT_W'(1)) ||
                       (is_seg && ram_rd_data.frame_end);

    rxdr_seg_eval u_seg_eval (
        .size   (base_size),
        .ovf_in (base_ovf),
        .is_end (ram_rd_data.frame_end),
        .length (ram_rd_data.frame_length),
        .cap    (cap_reg),
        .res    (seg)
    );

    // Next state of the walk
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rxdr_pkg::ST_IDLE:
            begin
                if (in_accept && (func == rxdr_pkg::FUNC_RECEIVE))
                begin
                    state_next = rxdr_pkg::ST_FETCH;
                end
            end
            rxdr_pkg::ST_FETCH:
            begin
                state_next = rxdr_pkg::ST_STEP;
            end
            rxdr_pkg::ST_STEP:
            begin
                if (step_go && last_step)
                begin
                    state_next = rxdr_pkg::ST_FINAL;
                end
            end
            rxdr_pkg::ST_FINAL:
            begin
                if (res_ready)
                begin
                    state_next = rxdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rxdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Update pointer, assembly state and owned bits
    always_comb
    begin
        phase_next = phase_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        size_next  = size_reg;
        ovf_next   = ovf_reg;
        found_next = found_reg;
        cap_next   = cap_reg;
        owned_next = owned_reg;
        case (state_reg)
            rxdr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (func == rxdr_pkg::FUNC_RECEIVE)
                    begin
                        cap_next   = capacity;
                        cnt_next   = rxdr_pkg::CNT_W'(rxdr_pkg::RING_ENTRIES);
                        phase_next = rxdr_pkg::PH_HUNT;
                        size_next  = '0;
                        ovf_next   = 1'b0;
                        found_next = 1'b0;
                    end
                    else if (idx_ok)
                    begin
                        owned_next[wr_idx] = 1'b1;
                    end
                end
            end
            rxdr_pkg::ST_STEP:
            begin
                if (step_go)
                begin
                    rp_next  = rp_adv;
                    cnt_next = cnt_reg - 1'b1;
                    if (!cur_owned)
                    begin
                        // Abandon any frame in progress and hunt again
                        phase_next = rxdr_pkg::PH_HUNT;
                        size_next  = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (is_frag)
                    begin
                        owned_next[rp_reg] = 1'b0;
                    end
                    else
                    begin
                        owned_next[rp_reg] = 1'b0;
                        phase_next         = rxdr_pkg::PH_ASM;
                        size_next          = seg.new_size;
                        ovf_next           = seg.ovf;
                        found_next         = ram_rd_data.frame_end;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Drive handshake, result and memory ports
    always_comb
    begin
        in_stall    = (state_reg != rxdr_pkg::ST_IDLE);
        res_valid   = 1'b0;
        res         = '0;
        ram_rd_addr = step_go ? rp_adv : rp_reg;

        ram_wr.en        = in_accept && (func == rxdr_pkg::FUNC_WRITE) && idx_ok;
        ram_wr.addr      = wr_idx;
        ram_wr.data.frame_start  = is_frame_start;
        ram_wr.data.frame_end    = is_frame_end;
        ram_wr.data.frame_length = frame_length;

        case (state_reg)
            rxdr_pkg::ST_STEP:
            begin
                res_valid          = cur_owned;
                res.released_entry = rxdr_pkg::IDX_W'(rp_reg);
                if (is_frag)
                begin
                    res.action = rxdr_pkg::ACT_FRAG;
                end
                else
                begin
                    res.action        = seg.copy ? rxdr_pkg::ACT_COPY : rxdr_pkg::ACT_DROP;
                    res.dest_offset   = base_size;
                    res.segment_bytes = seg.seg_bytes;
                end
            end
            rxdr_pkg::ST_FINAL:
            begin
                res_valid      = 1'b1;
                res.action     = rxdr_pkg::ACT_FINAL;
                res.frame_size = size_reg;
                res.last       = 1'b1;
                if (ovf_reg)
                begin
                    res.status = rxdr_pkg::STS_OVERFLOW;
                end
                else if (found_reg)
                begin
                    res.status = rxdr_pkg::STS_OK;
                end
                else
                begin
                    res.status = rxdr_pkg::STS_NO_FRAME;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rxdr_pkg::ST_IDLE;
            phase_reg <= rxdr_pkg::PH_HUNT;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            size_reg  <= '0;
            ovf_reg   <= 1'b0;
            found_reg <= 1'b0;
            owned_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            size_reg  <= size_next;
            ovf_reg   <= ovf_next;
            found_reg <= found_next;
            owned_reg <= owned_next;
        end
    end

    // Hold the caller capacity
    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
    end

endmodule

// ===== hw/rtl/rx_descriptor_ring_frame_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// rx_descriptor_ring_frame_assembler_unit
// Receive descriptor ring frame assembler: top level with output register.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a descriptor-write item (func 0) marks
// one ring entry owned and stores its start, end and length, and yields
// nothing. A receive item (func 1) walks the ring from the read pointer and
// yields one item per released entry, then a final status item with last
// set. A receive passes through a fetch state, then steps through the ring
// entries visited (up to 32, one lap), then gives the final item. While the
// output is not stalled, the walk rate is set by the descriptor memory, read
// one entry a cycle with registered read data. in_stall stays high for the
// whole walk.
// Output channel (out_valid / out_stall): results pass through one output
// register; while it is stalled the walk holds at its current entry, and a
// new item is taken as soon as the walk is done, even if the final item
// still waits.
// Reset clears the read pointer and all owned bits at once; descriptor
// contents are not cleared and are read only for owned entries.
// ----------------------------------------------------------------------------
module rx_descriptor_ring_frame_assembler_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [rxdr_pkg::IDX_W-1:0]     entry_index,
    input  logic                           is_frame_start,
    input  logic                           is_frame_end,
    input  logic [rxdr_pkg::LEN_W-1:0]     frame_length,
    input  logic [rxdr_pkg::LEN_W-1:0]     capacity,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rxdr_pkg::IDX_W-1:0]     released_entry,
    output logic [rxdr_pkg::ACT_W-1:0]     action,
    output logic [rxdr_pkg::LEN_W-1:0]     dest_offset,
    output logic [rxdr_pkg::SEG_W-1:0]     segment_bytes,
    output logic [rxdr_pkg::STS_W-1:0]     status,
    output logic [rxdr_pkg::LEN_W-1:0]     frame_size,
    output logic                           last
);

    rxdr_pkg::ram_wr_t              ram_wr;
    logic [rxdr_pkg::PTR_W-1:0]     ram_rd_addr;
    rxdr_pkg::desc_t                ram_rd_data;
    logic                           res_valid;
    rxdr_pkg::result_t              res;
    logic                           out_free;

    logic                           out_valid_reg, out_valid_next;
    rxdr_pkg::result_t              out_data_reg, out_data_next;

    rxdr_desc_ram u_desc_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rxdr_walker u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .entry_index    (entry_index),
        .is_frame_start (is_frame_start),
        .is_frame_end   (is_frame_end),
        .frame_length   (frame_length),
        .capacity       (capacity),
        .res_ready      (out_free),
        .res_valid      (res_valid),
        .res            (res),
        .ram_wr         (ram_wr),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

    // Output register is free when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;

    // Load a new item, drop a taken one
    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign released_entry = out_data_reg.released_entry;
    assign action         = out_data_reg.action;
    assign dest_offset    = out_data_reg.dest_offset;
    assign segment_bytes  = out_data_reg.segment_bytes;
    assign status         = out_data_reg.status;
    assign frame_size     = out_data_reg.frame_size;
    assign last           = out_data_reg.last;

    // A receive item blocks the input while the ring is walked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == rxdr_pkg::FUNC_RECEIVE)) |=> in_stall)
        else $error("input taken during a ring walk");

    // Only copy items carry a byte count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != rxdr_pkg::ACT_COPY)) |-> (segment_bytes == '0))
        else $error("byte count on a non-copy item");

    // Status is reported on the final item only
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != rxdr_pkg::STS_OK)) |-> last)
        else $error("status on a non-final item");

    // The final item is a status item with no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ((action == rxdr_pkg::ACT_FINAL) && (released_entry == '0)))
        else $error("malformed final item");

endmodule
